/* rtl/jas_pkg.sv */
// Shared types, widths and constants for the joystick axis shaper.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package jas_pkg;

	localparam int SAMPLE_W   = 10;
	localparam int MAG_W      = 8;
	localparam int SLEW_W     = 8;
	localparam int FS_W       = 8;
	localparam int NUM_W      = SAMPLE_W + FS_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;
	localparam int QUEUE_DEPTH = 2;

	// slew limiting is active for settings up to this value
	localparam logic [SLEW_W-1:0] SLEW_OFF_ABOVE = 8'd253;
	// (x * 205) >> 10 equals x / 5 for every x up to 255
	localparam logic [7:0] SLEW_RECIP = 8'd205;
	localparam int SLEW_SHIFT = 10;

	localparam logic [SAMPLE_W-1:0] LAST_RESET = 10'd511;
	localparam logic [MAG_W-1:0]    MAG_MAX    = 8'd255;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_SLEW        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOTTOM      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIDDLE_LOW  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIDDLE_HIGH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TOP         = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT      = 3'd6;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_POS  = 2'd1,
		DIR_NEG  = 2'd2
	} dir_t;

	typedef struct packed {
		logic [SLEW_W-1:0]   slew_setting;
		logic [FS_W-1:0]     full_scale;
		logic [SAMPLE_W-1:0] bottom_point;
		logic [SAMPLE_W-1:0] middle_low;
		logic [SAMPLE_W-1:0] middle_high;
		logic [SAMPLE_W-1:0] top_point;
		logic                invert_axis;
	} cfg_t;

	// one classified sample on its way from front to back
	typedef struct packed {
		logic [SAMPLE_W-1:0] distance;
		logic [SAMPLE_W-1:0] span;
		dir_t                dir;
	} item_t;

endpackage

`default_nettype wire

/* rtl/jas_front.sv */
// Front end: takes samples, applies slew limiting, classifies against the
// dead band and produces distance/span/direction. Depends on jas_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jas_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire jas_pkg::cfg_t                 cfg,
	input  wire logic                          push,
	input  wire logic [jas_pkg::SAMPLE_W-1:0]  sample,
	output logic                               full,
	output jas_pkg::item_t                     item,
	input  wire logic                          item_ready,
	output logic                               item_valid
);

	logic                          v_s1, v_s2;
	logic [jas_pkg::SAMPLE_W-1:0]  s_s1;
	jas_pkg::item_t                item_s2;
	logic [jas_pkg::SAMPLE_W-1:0]  last_q;

	logic                          accept, adv1, adv2, s2_free;
	logic                          slew_on;
	logic [jas_pkg::SLEW_W:0]      slew_p2;
	logic [16:0]                   slew_prod;
	logic [jas_pkg::SAMPLE_W-1:0]  step, lim;
	jas_pkg::item_t                cls;
	logic [jas_pkg::SAMPLE_W-1:0]  from;

	assign full       = v_s1;
	assign accept     = push && !v_s1;
	assign adv2       = v_s2 && item_ready;
	assign s2_free    = !v_s2 || adv2;
	assign adv1       = v_s1 && s2_free;
	assign item       = item_s2;
	assign item_valid = v_s2;

	// step = (setting + 2) / 5 via reciprocal multiply
	always_comb begin
		slew_on   = cfg.slew_setting <= jas_pkg::SLEW_OFF_ABOVE;
		slew_p2   = {1'b0, cfg.slew_setting} + 9'd2;
		slew_prod = 17'(slew_p2) * 17'(jas_pkg::SLEW_RECIP);
		step      = jas_pkg::SAMPLE_W'(slew_prod[16:jas_pkg::SLEW_SHIFT]);
		lim       = sample;
		if (sample > last_q && (sample - last_q) > step) begin
			lim = last_q + step;
		end else if (last_q > sample && (last_q - sample) > step) begin
			lim = last_q - step;
		end
		if (!slew_on) begin
			lim = sample;
		end
	end

	// dead band classification
	always_comb begin
		from = (s_s1 > cfg.bottom_point) ? s_s1 : cfg.bottom_point;
		cls  = '{distance: '0, span: '0, dir: jas_pkg::DIR_NONE};
		if (s_s1 < cfg.middle_low) begin
			cls.distance = (cfg.middle_low > from) ? cfg.middle_low - from : '0;
			cls.span = (cfg.middle_low > cfg.bottom_point) ?
				cfg.middle_low - cfg.bottom_point : '0;
			cls.dir  = jas_pkg::DIR_NEG;
		end else if (s_s1 > cfg.middle_high) begin
			cls.distance = s_s1 - cfg.middle_high;
			cls.span = (cfg.top_point > cfg.middle_high) ?
				cfg.top_point - cfg.middle_high : '0;
			cls.dir  = jas_pkg::DIR_POS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			last_q <= jas_pkg::LAST_RESET;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
				if (slew_on) begin
					last_q <= lim;
				end
			end else if (adv1) begin
				v_s1 <= 1'b0;
			end
			if (adv1) begin
				v_s2 <= 1'b1;
			end else if (adv2) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s_s1 <= lim;
		end
		if (adv1) begin
			item_s2 <= cls;
		end
	end

endmodule

`default_nettype wire

/* rtl/jas_queue.sv */
// Short FIFO of classified items between front and back end.
// Depends on jas_pkg for the item type.
`timescale 1ns / 1ps
`default_nettype none

module jas_queue #(
	parameter int DEPTH = jas_pkg::QUEUE_DEPTH  // power of two, 2 or more
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire jas_pkg::item_t  wr_item,
	input  wire logic            wr_valid,   // valid from producer
	output logic                 wr_full,
	output jas_pkg::item_t       rd_item,
	input  wire logic            rd_take,
	output logic                 rd_empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	jas_pkg::item_t     mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_wr, do_rd;

	assign wr_full  = count_q == CNT_W'(DEPTH);
	assign rd_empty = count_q == '0;
	assign do_wr    = wr_valid && !wr_full;
	assign do_rd    = rd_take && !rd_empty;
	assign rd_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue occupancy beyond depth");

endmodule

`default_nettype wire

/* rtl/jas_back.sv */
// Back end: scales distance by full_scale/span with a bit-serial restoring
// divider, saturates, sets direction and holds the result. Depends on jas_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jas_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire jas_pkg::cfg_t               cfg,
	input  wire jas_pkg::item_t              item,
	input  wire logic                        item_empty,
	output logic                             item_take,
	input  wire logic                        pop,
	output logic                             out_valid,
	output logic [jas_pkg::MAG_W-1:0]        magnitude,
	output jas_pkg::dir_t                    direction
);

	localparam int CNT_W = $clog2(jas_pkg::NUM_W);
	localparam int SW    = jas_pkg::SAMPLE_W;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t                          state_q;
	jas_pkg::item_t                  itm_q;
	logic [jas_pkg::NUM_W-1:0]       num_q, num_next;
	logic [SW-1:0]                   rem_q, rem_next;
	logic [CNT_W-1:0]                cnt_q;
	logic [jas_pkg::MAG_W-1:0]       res_q, res_div;
	logic                            out_valid_q;
	logic [jas_pkg::MAG_W-1:0]       mag_q;
	jas_pkg::dir_t                   dir_q, dir_fin;
	logic [SW:0]                     part, trial;
	logic                            ge, out_load;

	assign item_take = (state_q == ST_IDLE) && !item_empty;
	assign out_valid = out_valid_q;
	assign magnitude = mag_q;
	assign direction = dir_q;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || pop);

	// one quotient bit per cycle
	always_comb begin
		part     = {rem_q, num_q[jas_pkg::NUM_W-1]};
		trial    = part - {1'b0, itm_q.span};
		ge       = part >= {1'b0, itm_q.span};
		rem_next = ge ? trial[SW-1:0] : part[SW-1:0];
		num_next = {num_q[jas_pkg::NUM_W-2:0], ge};
		res_div  = (|num_next[jas_pkg::NUM_W-1:jas_pkg::MAG_W]) ?
			jas_pkg::MAG_MAX : num_next[jas_pkg::MAG_W-1:0];
	end

	always_comb begin
		dir_fin = itm_q.dir;
		if (res_q == '0) begin
			dir_fin = jas_pkg::DIR_NONE;
		end else if (cfg.invert_axis) begin
			dir_fin = (itm_q.dir == jas_pkg::DIR_NEG) ? jas_pkg::DIR_POS : jas_pkg::DIR_NEG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!item_empty) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (itm_q.distance == '0 || itm_q.span == '0) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			itm_q <= item;
		end
		if (state_q == ST_MUL) begin
			num_q <= jas_pkg::NUM_W'(itm_q.distance) * jas_pkg::NUM_W'(cfg.full_scale);
			rem_q <= '0;
			cnt_q <= CNT_W'(jas_pkg::NUM_W - 1);
			res_q <= (itm_q.distance == '0) ? '0 : jas_pkg::MAG_MAX;
		end
		if (state_q == ST_DIV) begin
			num_q <= num_next;
			rem_q <= rem_next;
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				res_q <= res_div;
			end
		end
		if (out_load) begin
			mag_q <= res_q;
			dir_q <= dir_fin;
		end
	end

	a_div_span: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> itm_q.span != '0 && rem_q < itm_q.span)
		else $error("divider remainder not below a nonzero span");

	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item_take |=> state_q == ST_MUL)
		else $error("item taken but scaling did not start");

endmodule

`default_nettype wire

/* rtl/joystick_axis_shaper.sv */
// Joystick axis shaper: slew limiting, dead band, scaling and direction.
// Top level; instantiates jas_front, jas_queue, jas_back; uses jas_pkg.
//
// Usage:
//   Input channel: drive axis_sample and raise push; a transfer happens at
//   a clock edge with push high and full low. Result channel: while empty
//   is low, magnitude and direction show the oldest result; a transfer
//   happens at an edge with pop high and empty low.
//   Configuration: wr_en/wr_index/wr_data write register wr_index
//   (0 slew, 1 full scale, 2 bottom, 3 middle low, 4 middle high,
//   5 top, 6 invert); index 7 is ignored. Write only while idle.
// Path: a scaled sample passes the front stages into the queue, then the
//   back end's multiply and serial divide; a result that needs no division
//   (dead band, zero distance, zero span) skips the divide.
// Flow: the back end takes a new item only when idle, so the serial divider
//   sets the pace (one quotient bit a cycle). The front holds up to two items
//   and the queue holds QUEUE_DEPTH more.
// Reset: registers return to their defaults, last limited sample to 511,
//   all stages and the queue empty.
// Stall: a held result keeps the back end in its final state; the queue
//   then the front fill up and full rises. Nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none

module joystick_axis_shaper #(
	parameter int QUEUE_DEPTH = jas_pkg::QUEUE_DEPTH  // power of two, 2 or more
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration port
	input  wire logic                            wr_en,
	input  wire logic [jas_pkg::CFG_IDX_W-1:0]   wr_index,
	input  wire logic [jas_pkg::CFG_DATA_W-1:0]  wr_data,
	// input channel
	input  wire logic                            push,
	output logic                                 full,
	input  wire logic [jas_pkg::SAMPLE_W-1:0]    axis_sample,
	// result channel
	output logic                                 empty,
	input  wire logic                            pop,
	output logic [jas_pkg::MAG_W-1:0]            magnitude,
	output logic [1:0]                           direction
);

	jas_pkg::cfg_t   cfg_q;
	jas_pkg::item_t  front_item, queue_item;
	logic            front_valid, front_ready;
	logic            q_full, q_empty, back_take, out_valid;
	jas_pkg::dir_t   back_dir;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slew_setting <= 8'd255;
			cfg_q.full_scale   <= 8'd255;
			cfg_q.bottom_point <= 10'd0;
			cfg_q.middle_low   <= 10'd496;
			cfg_q.middle_high  <= 10'd526;
			cfg_q.top_point    <= 10'd1023;
			cfg_q.invert_axis  <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				jas_pkg::REG_SLEW:        cfg_q.slew_setting <= wr_data[jas_pkg::SLEW_W-1:0];
				jas_pkg::REG_FULL_SCALE:  cfg_q.full_scale   <= wr_data[jas_pkg::FS_W-1:0];
				jas_pkg::REG_BOTTOM:      cfg_q.bottom_point <= wr_data[jas_pkg::SAMPLE_W-1:0];
				jas_pkg::REG_MIDDLE_LOW:  cfg_q.middle_low   <= wr_data[jas_pkg::SAMPLE_W-1:0];
				jas_pkg::REG_MIDDLE_HIGH: cfg_q.middle_high  <= wr_data[jas_pkg::SAMPLE_W-1:0];
				jas_pkg::REG_TOP:         cfg_q.top_point    <= wr_data[jas_pkg::SAMPLE_W-1:0];
				jas_pkg::REG_INVERT:      cfg_q.invert_axis  <= wr_data[0];
				default: begin
				end
			endcase
		end
	end

	assign front_ready = !q_full;

	jas_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.push       (push),
		.sample     (axis_sample),
		.full       (full),
		.item       (front_item),
		.item_ready (front_ready),
		.item_valid (front_valid)
	);

	jas_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_item  (front_item),
		.wr_valid (front_valid),
		.wr_full  (q_full),
		.rd_item  (queue_item),
		.rd_take  (back_take),
		.rd_empty (q_empty)
	);

	jas_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item       (queue_item),
		.item_empty (q_empty),
		.item_take  (back_take),
		.pop        (pop),
		.out_valid  (out_valid),
		.magnitude  (magnitude),
		.direction  (back_dir)
	);

	assign empty     = !out_valid;
	assign direction = back_dir;

	a_zero_none: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && magnitude == '0 |-> direction == jas_pkg::DIR_NONE)
		else $error("zero magnitude with a direction");

	a_nonzero_dir: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && magnitude != '0 |-> direction != jas_pkg::DIR_NONE)
		else $error("nonzero magnitude without a direction");

endmodule

`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for joystick_axis_shaper: slew limit, dead band, scaling, direction.
// Depends on rtl/jas_pkg.sv and rtl/joystick_axis_shaper.sv; a built-in predictor supplies
// the expected magnitude and direction for every sample transfer.
`timescale 1ns / 1ps

module tb;
	import jas_pkg::*;

	localparam int HALF_PERIOD  = 6;
	localparam int SLEW_DIVISOR = 5;
	localparam int DRAIN_CYCLES = 40;   // margin beyond the input-to-result latency
	localparam int HOLD_CYCLES  = 300;  // long result hold-off for the backpressure test
	localparam int MAX_REPORTS  = 10;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	// expected result for one sample
	typedef struct {
		logic [MAG_W-1:0] mag;
		dir_t             dir;
	} shape_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  wr_index = '0;
	logic [CFG_DATA_W-1:0] wr_data = '0;
	logic                  push = 1'b0;
	logic                  full;
	logic [SAMPLE_W-1:0]   axis_sample = '0;
	logic                  empty;
	logic                  pop = 1'b0;
	logic [MAG_W-1:0]      magnitude;
	logic [1:0]            direction;

	// predictor copy of the registers and the slew state
	cfg_t shaper_cfg = '{slew_setting: 8'd255, full_scale: 8'd255, bottom_point: 10'd0,
		middle_low: 10'd496, middle_high: 10'd526, top_point: 10'd1023, invert_axis: 1'b0};
	logic [SAMPLE_W-1:0] held_sample = LAST_RESET;

	shape_t pending_shapes[$];
	int     mismatch_count = 0;
	int     send_idle_pct = 0;
	int     stall_pct = 0;
	// hold-off request: the test toggles hold_req, the result process counts the cycles
	logic   hold_req = 1'b0;
	logic   hold_ack = 1'b0;
	int     hold_left = 0;

	joystick_axis_shaper uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.push       (push),
		.full       (full),
		.axis_sample(axis_sample),
		.empty      (empty),
		.pop        (pop),
		.magnitude  (magnitude),
		.direction  (direction)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// Predict one result and advance the slew state. Called once per accepted sample.
	function automatic shape_t shape_sample(input logic [SAMPLE_W-1:0] raw);
		int unsigned s, prev, step, lo_from, distance, span, mag;
		dir_t        d;
		shape_t      r;
		s = raw;
		if (shaper_cfg.slew_setting <= SLEW_OFF_ABOVE) begin
			step = (shaper_cfg.slew_setting + 2) / SLEW_DIVISOR;
			prev = held_sample;
			if (s > prev && s - prev > step)
				s = prev + step;
			else if (prev > s && prev - s > step)
				s = prev - step;
			held_sample = SAMPLE_W'(s);
		end
		distance = 0;
		span = 0;
		d = DIR_NONE;
		if (s < shaper_cfg.middle_low) begin
			// low side measures from the larger of sample and bottom point
			lo_from = (s > shaper_cfg.bottom_point) ? s : shaper_cfg.bottom_point;
			distance = (shaper_cfg.middle_low > lo_from) ? shaper_cfg.middle_low - lo_from : 0;
			span = (shaper_cfg.middle_low > shaper_cfg.bottom_point) ?
				shaper_cfg.middle_low - shaper_cfg.bottom_point : 0;
			d = DIR_NEG;
		end else if (s > shaper_cfg.middle_high) begin
			distance = s - shaper_cfg.middle_high;
			span = (shaper_cfg.top_point > shaper_cfg.middle_high) ?
				shaper_cfg.top_point - shaper_cfg.middle_high : 0;
			d = DIR_POS;
		end
		if (distance == 0)
			mag = 0;
		else if (span == 0)
			mag = MAG_MAX;  // zero span saturates
		else begin
			mag = (distance * shaper_cfg.full_scale) / span;
			if (mag > MAG_MAX)
				mag = MAG_MAX;
		end
		if (mag == 0)
			d = DIR_NONE;
		else if (shaper_cfg.invert_axis)
			d = (d == DIR_NEG) ? DIR_POS : DIR_NEG;
		r.mag = MAG_W'(mag);
		r.dir = d;
		return r;
	endfunction

	// Offer one sample, with random idle cycles ahead of it; returns at the transfer edge.
	// push stays high afterwards so back-to-back samples see no gap.
	task automatic send_sample(input logic [SAMPLE_W-1:0] s);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		axis_sample <= s;
		@(posedge clk);
		while (full)
			@(posedge clk);
		pending_shapes.push_back(shape_sample(s));
	endtask

	// Stop offering and wait until every expected result is in, plus latency slack.
	task automatic settle();
		push <= 1'b0;
		while (pending_shapes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One register write; the predictor copy keeps only the register's width.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_SLEW:        shaper_cfg.slew_setting = data[SLEW_W-1:0];
			REG_FULL_SCALE:  shaper_cfg.full_scale = data[FS_W-1:0];
			REG_BOTTOM:      shaper_cfg.bottom_point = data;
			REG_MIDDLE_LOW:  shaper_cfg.middle_low = data;
			REG_MIDDLE_HIGH: shaper_cfg.middle_high = data;
			REG_TOP:         shaper_cfg.top_point = data;
			REG_INVERT:      shaper_cfg.invert_axis = data[0];
			default: ;
		endcase
	endtask

	// Rewrite every register once the block is idle. Unused upper data bits carry junk
	// so the narrow registers are seen to drop them.
	task automatic set_axis_setup(input logic [7:0] slew, input logic [7:0] fs,
			input logic [9:0] bottom, input logic [9:0] mid_lo, input logic [9:0] mid_hi,
			input logic [9:0] top, input logic inv);
		settle();
		write_register(REG_SLEW, {2'($urandom_range(3)), slew});
		write_register(REG_FULL_SCALE, {2'($urandom_range(3)), fs});
		write_register(REG_BOTTOM, bottom);
		write_register(REG_MIDDLE_LOW, mid_lo);
		write_register(REG_MIDDLE_HIGH, mid_hi);
		write_register(REG_TOP, top);
		write_register(REG_INVERT, {9'($urandom_range(511)), inv});
	endtask

	function automatic logic [SAMPLE_W-1:0] jitter(input int center, input int spread);
		int v;
		v = center + int'($urandom_range(2 * spread)) - spread;
		if (v < 0)
			v = 0;
		if (v > 1023)
			v = 1023;
		return SAMPLE_W'(v);
	endfunction

	// Random sample biased toward the interesting points of the current setup.
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		int sel;
		sel = $urandom_range(99);
		if (sel < 40)
			return SAMPLE_W'($urandom_range(1023));
		else if (sel < 55)
			return jitter(shaper_cfg.middle_low, 6);
		else if (sel < 70)
			return jitter(shaper_cfg.middle_high, 6);
		else if (sel < 80)
			return jitter(shaper_cfg.bottom_point, 4);
		else if (sel < 88)
			return jitter(shaper_cfg.top_point, 4);
		else if (sel < 94)
			return jitter(held_sample, 60);
		else
			return $urandom_range(1) ? SAMPLE_W'(1023) : SAMPLE_W'(0);
	endfunction

	task automatic apply_random_setup();
		logic [7:0] slew, fs;
		logic [9:0] b, lo, hi, t;
		int         pick;
		pick = $urandom_range(3);
		slew = (pick == 0) ? 8'($urandom_range(254, 255)) :
			(pick == 1) ? 8'(253) : 8'($urandom_range(253));
		pick = $urandom_range(5);
		fs = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(255));
		pick = $urandom_range(9);
		if (pick < 7) begin
			// ordered travel: bottom <= middle_low <= middle_high <= top
			b  = 10'($urandom_range(300));
			lo = 10'($urandom_range(600, b));
			hi = 10'($urandom_range(800, lo));
			t  = 10'($urandom_range(1023, hi));
		end else if (pick < 9) begin
			b  = 10'($urandom_range(1023));
			lo = 10'($urandom_range(1023));
			hi = 10'($urandom_range(1023));
			t  = 10'($urandom_range(1023));
		end else begin
			b  = 10'd0;
			lo = 10'd1023;
			hi = 10'd1023;
			t  = 10'd1023;
		end
		set_axis_setup(slew, fs, b, lo, hi, t, 1'($urandom_range(1)));
	endtask

	// ---- tests ----

	// Reset registers: slew off, full scale 255, travel 0..1023 with band 496..526.
	task automatic test_reset_defaults();
		send_sample(10'd0);
		send_sample(10'd1023);
		send_sample(10'd495);
		send_sample(10'd496);
		send_sample(10'd526);
		send_sample(10'd527);
		send_sample(10'd511);
		send_sample(10'h2aa);
		send_sample(10'h155);
	endtask

	// Band geometry corners: sample below bottom, zero spans, reversed points, zero scale.
	task automatic test_band_geometry();
		set_axis_setup(8'd255, 8'd200, 10'd300, 10'd496, 10'd526, 10'd1023, 1'b0);
		send_sample(10'd100);    // below bottom: measured from bottom, full deflection
		send_sample(10'd400);
		set_axis_setup(8'd255, 8'd255, 10'd500, 10'd500, 10'd520, 10'd520, 1'b0);
		send_sample(10'd0);      // zero span and zero distance
		send_sample(10'd1023);
		set_axis_setup(8'd255, 8'd255, 10'd700, 10'd500, 10'd600, 10'd550, 1'b0);
		send_sample(10'd100);    // bottom above band edge: zero distance
		send_sample(10'd1023);   // top below band edge: zero span
		set_axis_setup(8'd255, 8'd0, 10'd0, 10'd496, 10'd526, 10'd1023, 1'b0);
		send_sample(10'd0);      // zero full scale: magnitude 0, no direction
	endtask

	task automatic test_invert();
		set_axis_setup(8'd255, 8'd255, 10'd0, 10'd496, 10'd526, 10'd1023, 1'b1);
		send_sample(10'd0);
		send_sample(10'd1023);
		send_sample(10'd511);
	endtask

	// Slew: step 0 holds the value, 253 is the largest limited setting, 254 turns it off.
	task automatic test_slew_limit();
		set_axis_setup(8'd0, 8'd255, 10'd0, 10'd496, 10'd526, 10'd1023, 1'b0);
		send_sample(10'd1023);
		send_sample(10'd0);
		set_axis_setup(8'd253, 8'd255, 10'd0, 10'd496, 10'd526, 10'd1023, 1'b0);
		send_sample(10'd1023);
		send_sample(10'd1023);
		send_sample(10'd0);
		set_axis_setup(8'd254, 8'd255, 10'd0, 10'd496, 10'd526, 10'd1023, 1'b0);
		send_sample(10'd0);
	endtask

	// A write to the spare index must leave every register alone.
	task automatic test_unused_index();
		settle();
		write_register(REG_UNUSED, 10'h3ff);
		send_sample(10'd0);
		send_sample(10'd1023);
	endtask

	// Results held off for a long stretch while samples keep coming: full must throttle.
	task automatic test_backpressure();
		settle();
		send_idle_pct = 0;
		stall_pct = 0;
		hold_req <= ~hold_req;
		repeat (24) send_sample(pick_sample());
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall);
		send_idle_pct = idle_pct;
		stall_pct = stall;
		repeat (4) begin
			apply_random_setup();
			repeat (100) send_sample(pick_sample());
		end
	endtask

	// ---- result side: random pop, hold-off counter, and the compare ----
	always @(posedge clk) begin : result_check
		shape_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (pending_shapes.size() == 0) begin
					if (mismatch_count < MAX_REPORTS)
						$display("%0t: unexpected result magnitude %0d direction %0d",
							$time, magnitude, direction);
					mismatch_count++;
				end else begin
					want = pending_shapes.pop_front();
					if (magnitude !== want.mag || direction !== want.dir) begin
						if (mismatch_count < MAX_REPORTS)
							$display("%0t: magnitude %0d expected %0d, direction %0d expected %0d",
								$time, magnitude, want.mag, direction, want.dir);
						mismatch_count++;
					end
				end
			end
			if (hold_req != hold_ack) begin
				hold_ack <= hold_req;
				hold_left <= HOLD_CYCLES;
				pop <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_band_geometry();
		test_invert();
		test_slew_limit();
		test_unused_index();
		test_backpressure();
		test_random_traffic(0, 0);
		test_random_traffic(62, 0);
		test_random_traffic(0, 62);
		test_random_traffic(15, 15);

		settle();
		if (mismatch_count == 0 && pending_shapes.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#10_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
